// ===== rtl/core/ambient_backlight_controller_macros.svh =====
// assertion macros shared by the backlight controller modules
`ifndef AMBIENT_BACKLIGHT_CONTROLLER_MACROS_SVH
`define AMBIENT_BACKLIGHT_CONTROLLER_MACROS_SVH

// same-cycle implication
`define ABC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/abc_pkg.sv =====
// types, constants and codes of the ambient backlight controller
package abc_pkg;

    localparam int PWM_W      = 8;
    localparam int LIGHT_W    = 11;
    localparam int MIN_W      = 11;
    localparam int RAW_W      = 10;
    localparam int TAP_W      = 10;
    localparam int SH_W       = 9;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // shared divider
    localparam int QUOT_W = 18;
    localparam int DEN_W  = 11;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    localparam logic [LIGHT_W-1:0] LIGHT_FULL = 11'd1024;
    localparam logic [LIGHT_W-1:0] LIGHT_JUMP = 11'd30;
    localparam logic [PWM_W-1:0]   PWM_TOP    = 8'd255;
    localparam logic [MIN_W-1:0]   IDLE_MAX   = 11'd2047;
    // floor(x / 5) as (x * 6554) >> 15, exact for x below 2048
    localparam logic [12:0]        RECIP5     = 13'd6554;
    localparam int                 RECIP5_SH  = 15;

    // reset values
    localparam logic [PWM_W-1:0]   RST_USER_ON   = 8'd255;
    localparam logic [PWM_W-1:0]   RST_USER_OFF  = 8'd0;
    localparam logic [SH_W-1:0]    RST_SLIDER_H  = 9'd60;
    localparam logic [PWM_W-1:0]   RST_PWM       = 8'd255;
    localparam logic [LIGHT_W-1:0] RST_CAL_BRT_L = 11'd1024;
    localparam logic [PWM_W-1:0]   RST_CAL_BRT_P = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_USER_ON_PWM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_OFF_PWM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_MINUTE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MINUTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLIDER_HEIGHT  = 3'd6;

    typedef enum logic [CMD_W-1:0] {
        OP_SAMPLE = 3'd0,
        OP_MINUTE = 3'd1,
        OP_WAKE   = 3'd2,
        OP_CAL    = 3'd3,
        OP_SLIDE  = 3'd4,
        OP_OFF    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_BLEND,
        S_COMMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul;
        logic div_start;
        logic blend;
        logic commit;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/core/ambient_backlight_controller.sv =====
// Ambient backlight controller: one command in, one brightness/status result out.
//
// Input channel (in_valid/in_ready) carries cmd, sensor_raw, minute_of_day and
// tap_height. Output channel (out_valid/out_ready) carries backlight_pwm,
// display_off, refresh and light_level after the command has been applied.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, as the block leaves this unchecked.
// Minute tick, user tap, off, and slider taps outside the slider range go from
// accept to out_valid through PREP, COMMIT and EMIT. A sample with the sensor
// active, and a slider tap inside the range, also pass MUL, DSTART, DIV and BLEND:
// the interpolation quotient comes from a shared 18-step restoring divider.
// One transaction is processed at a time; the next one can be accepted in the cycle
// after its predecessor's result is loaded into the output register.
//
// The output register holds its transaction while out_ready is low; a new input
// can be accepted meanwhile, but its result waits until the register is free.
// Reset clears the state machine and restores register and calibration
// defaults; no clearing pass is needed.
module ambient_backlight_controller
    import abc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [RAW_W-1:0]        sensor_raw,
    input  logic [MIN_W-1:0]        minute_of_day,
    input  logic signed [TAP_W-1:0] tap_height,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PWM_W-1:0]        backlight_pwm,
    output logic                    display_off,
    output logic                    refresh,
    output logic [LIGHT_W-1:0]      light_level
);

    ctl_t c;
    sts_t s;

    abc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .s         (s),
        .c         (c)
    );

    abc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .c             (c),
        .s             (s),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sensor_raw    (sensor_raw),
        .minute_of_day (minute_of_day),
        .tap_height    (tap_height),
        .backlight_pwm (backlight_pwm),
        .display_off   (display_off),
        .refresh       (refresh),
        .light_level   (light_level)
    );

endmodule

// ===== rtl/core/abc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module abc_div
    import abc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QUOT_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUOT_W-1:0] quot,
    output logic              done
);

`include "ambient_backlight_controller_macros.svh"

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, q_reg[QUOT_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(QUOT_W);
            done_next = 1'b0;
            q_next    = num;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = {q_reg[QUOT_W-2:0], ge};
            rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

    `ABC_ASSERT_NEXT(a_div_restart, start, !done && cnt_reg == CNT_W'(QUOT_W), "divider did not restart")

endmodule

// ===== rtl/core/abc_dp.sv =====
// datapath: configuration, controller state, interpolation and blend arithmetic
module abc_dp
    import abc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  c,
    output sts_t                  s,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [RAW_W-1:0]      sensor_raw,
    input  logic [MIN_W-1:0]      minute_of_day,
    input  logic signed [TAP_W-1:0] tap_height,
    output logic [PWM_W-1:0]      backlight_pwm,
    output logic                  display_off,
    output logic                  refresh,
    output logic [LIGHT_W-1:0]    light_level
);

`include "ambient_backlight_controller_macros.svh"

    // configuration
    logic [PWM_W-1:0]   user_on_reg, user_off_reg;
    logic [MIN_W-1:0]   on_min_reg, off_min_reg, idle_limit_reg;
    logic               sensor_reg;
    logic [SH_W-1:0]    slider_h_reg;

    // captured transaction
    op_t                   cmd_reg;
    logic [RAW_W-1:0]      raw_reg;
    logic [MIN_W-1:0]      minute_reg;
    logic signed [TAP_W-1:0] tap_reg;

    // controller state
    logic [PWM_W-1:0]   pwm_reg, pwm_next;
    logic               off_reg, off_next;
    logic [LIGHT_W-1:0] light_reg, light_next;
    logic [LIGHT_W-1:0] cbl_reg, cbl_next, cdl_reg, cdl_next;
    logic [PWM_W-1:0]   cbp_reg, cbp_next, cdp_reg, cdp_next;
    logic [MIN_W-1:0]   idle_reg, idle_next;
    logic [MIN_W-1:0]   lmin_reg, lmin_next;
    logic               lmin_vld_reg, lmin_vld_next;
    logic               refresh_reg, refresh_next;

    // working registers
    logic [LIGHT_W-1:0]     light_new_reg;
    logic signed [8:0]      mul_a_reg;
    logic signed [11:0]     mul_b_reg;
    logic [DEN_W-1:0]       den_reg;
    logic                   den_neg_reg;
    logic                   need_div_reg;
    logic [PWM_W-1:0]       sld_fix_reg;
    logic signed [20:0]     prod_reg;
    logic [PWM_W-1:0]       res_reg;

    // output register
    logic [PWM_W-1:0]   out_pwm_reg;
    logic               out_off_reg;
    logic               out_refresh_reg;
    logic [LIGHT_W-1:0] out_light_reg;

    // prep terms
    logic [LIGHT_W-1:0]   fresh;
    logic [LIGHT_W:0]     light_sum;
    logic [LIGHT_W-1:0]   light_new;
    logic                 sample_act;
    logic signed [11:0]   del;
    logic signed [8:0]    prange;
    logic signed [11:0]   lrange;
    logic signed [11:0]   lrange_abs;
    logic [DEN_W-1:0]     lr_mag;
    logic [SH_W-1:0]      h;
    logic signed [10:0]   t_ext;
    logic signed [10:0]   h_ext;
    logic                 t_gt;
    logic                 t_neg;
    logic signed [8:0]    hl;
    logic                 is_slider;
    logic                 need_div;

    // divide and blend terms
    logic signed [20:0]   prod_next;
    logic signed [20:0]   prod_abs;
    logic [QUOT_W-1:0]    div_num;
    logic [QUOT_W-1:0]    quot;
    logic                 div_done;
    logic signed [19:0]   quot_ext;
    logic signed [19:0]   qs;
    logic signed [19:0]   tsum;
    logic [PWM_W-1:0]     target;
    logic [LIGHT_W-1:0]   blend_x;
    logic [23:0]          blend_prod;
    logic signed [19:0]   sld_sum;

    // commit terms
    logic [PWM_W-1:0]   sld_val;
    logic [PWM_W-1:0]   p_lo;
    logic [PWM_W-1:0]   p_new;
    logic [LIGHT_W-1:0] ldiff;
    logic [LIGHT_W:0]   cal_sum;
    logic [LIGHT_W-1:0] cal_mid;
    logic [MIN_W-1:0]   idle_inc;
    logic               idle_hit;
    logic [PWM_W-1:0]   min_pwm;
    logic               min_new;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_on_reg    <= RST_USER_ON;
            user_off_reg   <= RST_USER_OFF;
            on_min_reg     <= '0;
            off_min_reg    <= '0;
            idle_limit_reg <= '0;
            sensor_reg     <= 1'b0;
            slider_h_reg   <= RST_SLIDER_H;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_USER_ON_PWM:    user_on_reg    <= cfg_data[PWM_W-1:0];
                REG_USER_OFF_PWM:   user_off_reg   <= cfg_data[PWM_W-1:0];
                REG_ON_MINUTE:      on_min_reg     <= cfg_data[MIN_W-1:0];
                REG_OFF_MINUTE:     off_min_reg    <= cfg_data[MIN_W-1:0];
                REG_IDLE_LIMIT:     idle_limit_reg <= cfg_data[MIN_W-1:0];
                REG_SENSOR_PRESENT: sensor_reg     <= cfg_data[0];
                REG_SLIDER_HEIGHT:  slider_h_reg   <= cfg_data[SH_W-1:0];
                default:            ;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (c.load_in)
        begin
            cmd_reg    <= op_t'(cmd);
            raw_reg    <= sensor_raw;
            minute_reg <= minute_of_day;
            tap_reg    <= tap_height;
        end
    end

    // prep: light smoothing, multiply operands, divisor
    assign fresh      = LIGHT_FULL - {1'b0, raw_reg};
    assign light_sum  = {1'b0, fresh} + {1'b0, light_reg};
    assign light_new  = light_sum[LIGHT_W:1];
    assign sample_act = sensor_reg && !off_reg;
    assign del        = $signed({1'b0, light_new}) - $signed({1'b0, cdl_reg});
    assign prange     = $signed({1'b0, cbp_reg}) - $signed({1'b0, cdp_reg});
    assign lrange     = $signed({1'b0, cbl_reg}) - $signed({1'b0, cdl_reg});
    assign lrange_abs = lrange[11] ? -lrange : lrange;
    assign lr_mag     = (lrange == '0) ? DEN_W'(1) : lrange_abs[DEN_W-1:0];

    assign h         = (slider_h_reg == '0) ? SH_W'(1) : slider_h_reg;
    assign t_ext     = {tap_reg[TAP_W-1], tap_reg};
    assign h_ext     = $signed({2'b00, h});
    assign t_gt      = t_ext > h_ext;
    assign t_neg     = tap_reg[TAP_W-1];
    assign hl        = $signed({1'b0, user_on_reg}) - $signed({1'b0, user_off_reg});
    assign is_slider = (cmd_reg == OP_CAL) || (cmd_reg == OP_SLIDE);

    always_comb
    begin
        need_div = 1'b0;
        unique case (cmd_reg)
            OP_SAMPLE: need_div = sample_act;
            OP_CAL,
            OP_SLIDE:  need_div = !t_gt && !t_neg;
            default:   need_div = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_div_reg <= 1'b0;
        end
        else if (c.prep)
        begin
            need_div_reg <= need_div;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c.prep)
        begin
            light_new_reg <= light_new;
            sld_fix_reg   <= t_gt ? user_on_reg : user_off_reg;
            if (is_slider)
            begin
                mul_a_reg   <= hl;
                mul_b_reg   <= 12'(t_ext);
                den_reg     <= {2'b00, h};
                den_neg_reg <= 1'b0;
            end
            else
            begin
                mul_a_reg   <= prange;
                mul_b_reg   <= del;
                den_reg     <= lr_mag;
                den_neg_reg <= lrange[11];
            end
        end
    end

    // product, then magnitude into the divider
    assign prod_next = 21'(mul_a_reg) * 21'(mul_b_reg);

    always_ff @(posedge clk)
    begin
        if (c.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_abs = prod_reg[20] ? -prod_reg : prod_reg;
    assign div_num  = prod_abs[QUOT_W-1:0];

    abc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c.div_start),
        .num   (div_num),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // signed quotient, interpolation target, blend
    assign quot_ext = $signed({2'b00, quot});
    assign qs       = (prod_reg[20] ^ den_neg_reg) ? -quot_ext : quot_ext;
    assign tsum     = $signed({12'b0, cdp_reg}) + qs;

    always_comb
    begin
        priority if (tsum[19])
        begin
            target = '0;
        end
        else if (tsum > 20'sd255)
        begin
            target = PWM_TOP;
        end
        else
        begin
            target = tsum[PWM_W-1:0];
        end
    end

    assign blend_x    = {3'b000, target} + {1'b0, pwm_reg, 2'b00} + LIGHT_W'(2);
    assign blend_prod = {13'b0, blend_x} * {11'b0, RECIP5};
    assign sld_sum    = $signed({12'b0, user_off_reg}) + qs;

    always_ff @(posedge clk)
    begin
        if (c.blend)
        begin
            res_reg <= is_slider ? sld_sum[PWM_W-1:0]
                                 : blend_prod[RECIP5_SH +: PWM_W];
        end
    end

    // commit terms
    assign sld_val = need_div_reg ? res_reg : sld_fix_reg;
    assign p_lo    = (res_reg < user_off_reg) ? user_off_reg : res_reg;
    assign p_new   = (p_lo > user_on_reg) ? user_on_reg : p_lo;
    assign ldiff   = (light_new_reg > light_reg) ? (light_new_reg - light_reg)
                                                 : (light_reg - light_new_reg);
    assign cal_sum = {1'b0, cbl_reg} + {1'b0, cdl_reg};
    assign cal_mid = cal_sum[LIGHT_W:1];

    assign idle_inc = (idle_reg == IDLE_MAX) ? IDLE_MAX : idle_reg + 1'b1;
    assign idle_hit = (idle_limit_reg != '0) && (idle_inc >= idle_limit_reg) && !off_reg;
    assign min_pwm  = idle_hit ? user_off_reg : pwm_reg;
    assign min_new  = !lmin_vld_reg || (minute_reg != lmin_reg);

    always_comb
    begin
        pwm_next      = pwm_reg;
        off_next      = off_reg;
        light_next    = light_reg;
        cbl_next      = cbl_reg;
        cdl_next      = cdl_reg;
        cbp_next      = cbp_reg;
        cdp_next      = cdp_reg;
        idle_next     = idle_reg;
        lmin_next     = lmin_reg;
        lmin_vld_next = lmin_vld_reg;
        refresh_next  = refresh_reg;
        if (c.commit)
        begin
            refresh_next = 1'b0;
            unique case (cmd_reg)
                OP_SAMPLE:
                begin
                    if (need_div_reg)
                    begin
                        light_next   = light_new_reg;
                        pwm_next     = p_new;
                        refresh_next = (p_new != pwm_reg) || (ldiff > LIGHT_JUMP);
                    end
                end
                OP_MINUTE:
                begin
                    idle_next = idle_inc;
                    if (idle_hit)
                    begin
                        pwm_next     = user_off_reg;
                        off_next     = 1'b1;
                        refresh_next = 1'b1;
                    end
                    if (min_new)
                    begin
                        lmin_next     = minute_reg;
                        lmin_vld_next = 1'b1;
                        priority if (minute_reg == on_min_reg)
                        begin
                            if (min_pwm != user_on_reg)
                            begin
                                pwm_next     = user_on_reg;
                                off_next     = 1'b0;
                                idle_next    = '0;
                                refresh_next = 1'b1;
                            end
                        end
                        else if (minute_reg == off_min_reg)
                        begin
                            if (min_pwm != user_off_reg)
                            begin
                                pwm_next     = user_off_reg;
                                off_next     = 1'b1;
                                refresh_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // neither scheduled minute
                        end
                    end
                end
                OP_WAKE:
                begin
                    idle_next = '0;
                    if (off_reg)
                    begin
                        pwm_next     = user_on_reg;
                        off_next     = 1'b0;
                        refresh_next = 1'b1;
                    end
                end
                OP_CAL:
                begin
                    pwm_next     = sld_val;
                    refresh_next = 1'b1;
                    if (light_reg > cal_mid)
                    begin
                        cbp_next = sld_val;
                        cbl_next = light_reg;
                    end
                    else
                    begin
                        cdp_next = sld_val;
                        cdl_next = light_reg;
                    end
                end
                OP_SLIDE:
                begin
                    pwm_next     = sld_val;
                    refresh_next = 1'b1;
                end
                OP_OFF:
                begin
                    pwm_next     = user_off_reg;
                    off_next     = 1'b1;
                    refresh_next = 1'b1;
                end
                default:
                begin
                    refresh_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_reg      <= RST_PWM;
            off_reg      <= 1'b0;
            light_reg    <= '0;
            cbl_reg      <= RST_CAL_BRT_L;
            cdl_reg      <= '0;
            cbp_reg      <= RST_CAL_BRT_P;
            cdp_reg      <= '0;
            idle_reg     <= '0;
            lmin_reg     <= '0;
            lmin_vld_reg <= 1'b0;
            refresh_reg  <= 1'b0;
        end
        else
        begin
            pwm_reg      <= pwm_next;
            off_reg      <= off_next;
            light_reg    <= light_next;
            cbl_reg      <= cbl_next;
            cdl_reg      <= cdl_next;
            cbp_reg      <= cbp_next;
            cdp_reg      <= cdp_next;
            idle_reg     <= idle_next;
            lmin_reg     <= lmin_next;
            lmin_vld_reg <= lmin_vld_next;
            refresh_reg  <= refresh_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (c.emit)
        begin
            out_pwm_reg     <= pwm_reg;
            out_off_reg     <= off_reg;
            out_refresh_reg <= refresh_reg;
            out_light_reg   <= light_reg;
        end
    end

    assign s.need_div    = need_div;
    assign s.div_done    = div_done;
    assign backlight_pwm = out_pwm_reg;
    assign display_off   = out_off_reg;
    assign refresh       = out_refresh_reg;
    assign light_level   = out_light_reg;

    `ABC_ASSERT_NOW(a_blend_needs_quot, c.blend, div_done, "blend before divider finished")
    `ABC_ASSERT_NEXT(a_off_cmd, c.commit && cmd_reg == OP_OFF,
        off_reg && pwm_reg == $past(user_off_reg), "off command not applied")

endmodule

// ===== rtl/core/abc_ctrl.sv =====
// controller state machine sequencing each transaction through the datapath
module abc_ctrl
    import abc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t s,
    output ctl_t c
);

`include "ambient_backlight_controller_macros.svh"

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_PREP;
            S_PREP:   state_next = s.need_div ? S_MUL : S_COMMIT;
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:    if (s.div_done) state_next = S_BLEND;
            S_BLEND:  state_next = S_COMMIT;
            S_COMMIT: state_next = S_EMIT;
            S_EMIT:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        c           = '0;
        c.load_in   = (state_reg == S_IDLE) && in_valid;
        c.prep      = (state_reg == S_PREP);
        c.mul       = (state_reg == S_MUL);
        c.div_start = (state_reg == S_DSTART);
        c.blend     = (state_reg == S_BLEND);
        c.commit    = (state_reg == S_COMMIT);
        c.emit      = (state_reg == S_EMIT) && out_free;
    end

    always_comb
    begin
        priority if (c.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ABC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && state_reg == S_PREP, "no prep after accepted transaction")
    `ABC_ASSERT_NEXT(a_emit_sets_valid, c.emit, out_valid && state_reg == S_IDLE, "emitted result not presented")

endmodule

// ===== dv/ambient_backlight_controller_test.sv =====
// self-checking testbench for the ambient backlight controller, predicted result queue
module ambient_backlight_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abc_pkg::*;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE_TICKS = 40;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [PWM_W-1:0]   level;
        logic               dark;
        logic               engaged;
        logic [LIGHT_W-1:0] light;
    } backlight_t;

    class brightness_tracker;
        // register copy
        logic [PWM_W-1:0]   on_pwm, off_pwm;
        logic [MIN_W-1:0]   on_min, off_min, idle_lim;
        logic               sensor_on;
        logic [SH_W-1:0]    slide_h;
        // block state copy
        logic [PWM_W-1:0]   pwm, bright_pwm, dim_pwm;
        logic               dark;
        logic [LIGHT_W-1:0] light, bright_light, dim_light;
        logic [MIN_W-1:0]   idle_minutes, seen_minute;
        logic               seen_valid;
        backlight_t         expected_levels[$];
        int                 failures;

        function new();
            on_pwm       = RST_USER_ON;
            off_pwm      = RST_USER_OFF;
            on_min       = '0;
            off_min      = '0;
            idle_lim     = '0;
            sensor_on    = 1'b0;
            slide_h      = RST_SLIDER_H;
            pwm          = RST_PWM;
            dark         = 1'b0;
            light        = '0;
            bright_light = RST_CAL_BRT_L;
            dim_light    = '0;
            bright_pwm   = RST_CAL_BRT_P;
            dim_pwm      = '0;
            idle_minutes = '0;
            seen_minute  = '0;
            seen_valid   = 1'b0;
            failures     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_USER_ON_PWM:    on_pwm    = val[PWM_W-1:0];
                REG_USER_OFF_PWM:   off_pwm   = val[PWM_W-1:0];
                REG_ON_MINUTE:      on_min    = val[MIN_W-1:0];
                REG_OFF_MINUTE:     off_min   = val[MIN_W-1:0];
                REG_IDLE_LIMIT:     idle_lim  = val[MIN_W-1:0];
                REG_SENSOR_PRESENT: sensor_on = val[0];
                REG_SLIDER_HEIGHT:  slide_h   = val[SH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PWM_W-1:0] slider_level(logic signed [TAP_W-1:0] tap);
            int t, h, lo, hi;
            t  = tap;
            h  = (slide_h == 0) ? 1 : int'(slide_h);
            lo = off_pwm;
            hi = on_pwm;
            if (t > h)
                return on_pwm;
            if (t < 0)
                return off_pwm;
            return PWM_W'(lo + ((hi - lo) * t) / h);
        endfunction

        function void note_command(op_t op, logic [RAW_W-1:0] raw, logic [MIN_W-1:0] minute,
                                   logic signed [TAP_W-1:0] tap);
            int         prev_light, prev_pwm, lrange, target, p, drift;
            bit         engaged;
            backlight_t res;
            engaged = 1'b0;
            case (op)
                OP_SAMPLE:
                begin
                    if (sensor_on && !dark)
                    begin
                        prev_light = light;
                        prev_pwm   = pwm;
                        light  = LIGHT_W'((int'(LIGHT_FULL) - int'(raw) + int'(light)) >> 1);
                        lrange = int'(bright_light) - int'(dim_light);
                        if (lrange == 0)
                            lrange = 1;
                        target = int'(dim_pwm) + ((int'(bright_pwm) - int'(dim_pwm)) *
                                 (int'(light) - int'(dim_light))) / lrange;
                        if (target < 0)
                            target = 0;
                        else if (target > int'(PWM_TOP))
                            target = PWM_TOP;
                        p = (target + 4 * int'(pwm) + 2) / 5;
                        if (p < int'(off_pwm))
                            p = off_pwm;
                        if (p > int'(on_pwm))
                            p = on_pwm;
                        pwm   = PWM_W'(p);
                        drift = int'(light) - prev_light;
                        if (drift < 0)
                            drift = -drift;
                        engaged = (int'(pwm) != prev_pwm) || (drift > int'(LIGHT_JUMP));
                    end
                end
                OP_MINUTE:
                begin
                    if (idle_minutes != IDLE_MAX)
                        idle_minutes++;
                    if (idle_lim != 0 && idle_minutes >= idle_lim && !dark)
                    begin
                        pwm     = off_pwm;
                        dark    = 1'b1;
                        engaged = 1'b1;
                    end
                    if (!(seen_valid && minute == seen_minute))
                    begin
                        seen_minute = minute;
                        seen_valid  = 1'b1;
                        if (minute == on_min)
                        begin
                            if (pwm != on_pwm)
                            begin
                                pwm          = on_pwm;
                                dark         = 1'b0;
                                idle_minutes = '0;
                                engaged      = 1'b1;
                            end
                        end
                        else if (minute == off_min)
                        begin
                            if (pwm != off_pwm)
                            begin
                                pwm     = off_pwm;
                                dark    = 1'b1;
                                engaged = 1'b1;
                            end
                        end
                    end
                end
                OP_WAKE:
                begin
                    idle_minutes = '0;
                    if (dark)
                    begin
                        pwm     = on_pwm;
                        dark    = 1'b0;
                        engaged = 1'b1;
                    end
                end
                OP_CAL:
                begin
                    pwm = slider_level(tap);
                    // nearer calibration point moves to the current reading
                    if (int'(light) > (int'(bright_light) + int'(dim_light)) / 2)
                    begin
                        bright_pwm   = pwm;
                        bright_light = light;
                    end
                    else
                    begin
                        dim_pwm   = pwm;
                        dim_light = light;
                    end
                    engaged = 1'b1;
                end
                OP_SLIDE:
                begin
                    pwm     = slider_level(tap);
                    engaged = 1'b1;
                end
                OP_OFF:
                begin
                    pwm     = off_pwm;
                    dark    = 1'b1;
                    engaged = 1'b1;
                end
                default: ;
            endcase
            res.level   = pwm;
            res.dark    = dark;
            res.engaged = engaged;
            res.light   = light;
            expected_levels.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $error("%s expected %0d actual %0d", field, want, got);
            end
        endfunction

        function void check_result(logic [PWM_W-1:0] level_o, logic dark_o, logic engaged_o,
                                   logic [LIGHT_W-1:0] light_o);
            backlight_t want;
            if (expected_levels.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $error("result with no transaction pending: backlight_pwm %0d", level_o);
                return;
            end
            want = expected_levels.pop_front();
            compare_field("backlight_pwm", want.level, level_o);
            compare_field("display_off", want.dark, dark_o);
            compare_field("refresh", want.engaged, engaged_o);
            compare_field("light_level", want.light, light_o);
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [CMD_W-1:0]        cmd = '0;
    logic [RAW_W-1:0]        sensor_raw = '0;
    logic [MIN_W-1:0]        minute_of_day = '0;
    logic signed [TAP_W-1:0] tap_height = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PWM_W-1:0]        backlight_pwm;
    logic                    display_off;
    logic                    refresh;
    logic [LIGHT_W-1:0]      light_level;

    brightness_tracker sb = new();
    bit                no_idle = 1'b0;
    int                cycle_count = 0;
    int                clock_minute = 0;
    int                ambient = 512;

    ambient_backlight_controller uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .sensor_raw(sensor_raw),
        .minute_of_day(minute_of_day),
        .tap_height(tap_height),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .backlight_pwm(backlight_pwm),
        .display_off(display_off),
        .refresh(refresh),
        .light_level(light_level)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // older result is retired before the new transaction is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(backlight_pwm, display_off, refresh, light_level);
            if (in_valid && in_ready)
                sb.note_command(op_t'(cmd), sensor_raw, minute_of_day, tap_height);
        end
    end

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : ready_driver
        int stall, run;
        @(posedge clk);
        forever
        begin
            stall = idle_gap();
            run   = $urandom_range(1, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        sb.set_register(idx, CFG_DATA_W'(val));
        @(posedge clk);
    endtask

    task automatic load_settings(int on_p, int off_p, int on_m, int off_m, int idle,
                                 int sensor, int height);
        write_reg(REG_USER_ON_PWM, on_p);
        write_reg(REG_USER_OFF_PWM, off_p);
        write_reg(REG_ON_MINUTE, on_m);
        write_reg(REG_OFF_MINUTE, off_m);
        write_reg(REG_IDLE_LIMIT, idle);
        write_reg(REG_SENSOR_PRESENT, sensor);
        write_reg(REG_SLIDER_HEIGHT, height);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_command(op_t op, logic [RAW_W-1:0] raw, logic [MIN_W-1:0] minute,
                                logic signed [TAP_W-1:0] tap);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        sensor_raw    <= raw;
        minute_of_day <= minute;
        tap_height    <= tap;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_random_item();
        int  r, t, h, raw;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_SAMPLE;
        else if (r < 60)
            op = OP_MINUTE;
        else if (r < 70)
            op = OP_WAKE;
        else if (r < 80)
            op = OP_CAL;
        else if (r < 95)
            op = OP_SLIDE;
        else
            op = OP_OFF;
        // sometimes wake a dark display so samples keep running
        if (sb.dark && $urandom_range(0, 3) == 0)
            op = OP_WAKE;

        ambient = ambient + int'($urandom_range(0, 80)) - 40;
        if (ambient < 0)
            ambient = 0;
        if (ambient > 1023)
            ambient = 1023;
        r = $urandom_range(0, 99);
        if (r < 60)
            raw = ambient;
        else if (r < 90)
            raw = $urandom_range(0, 1023);
        else if (r < 95)
            raw = 0;
        else
            raw = 1023;

        r = $urandom_range(0, 99);
        if (r < 40)
            clock_minute = (clock_minute + 1) % 1440;
        else if (r < 55)
            clock_minute = clock_minute;
        else if (r < 70)
            clock_minute = sb.on_min;
        else if (r < 85)
            clock_minute = sb.off_min;
        else
            clock_minute = $urandom_range(0, 1439);

        h = sb.slide_h;
        r = $urandom_range(0, 99);
        if (r < 60)
            t = $urandom_range(0, h);
        else if (r < 75)
            t = h + int'($urandom_range(1, 3));
        else if (r < 85)
            t = 0 - int'($urandom_range(1, 3));
        else
            t = int'($urandom_range(0, 1023)) - 512;
        if (t > 511)
            t = 511;

        send_command(op, RAW_W'(raw), MIN_W'(clock_minute), TAP_W'(t));
    endtask

    initial
    begin : stimulus
        int a, b, idle, sensor, height;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(250, 5, 100, 200, 3, 1, 60);
        send_command(OP_SAMPLE, 0, 0, 0);
        send_command(OP_SAMPLE, 1023, 0, 0);
        send_command(OP_SAMPLE, 512, 0, 0);
        send_command(OP_SLIDE, 0, 0, 511);
        send_command(OP_SLIDE, 0, 0, -512);
        send_command(OP_SLIDE, 0, 0, 0);
        send_command(OP_SLIDE, 0, 0, 60);
        send_command(OP_SLIDE, 0, 0, 61);
        send_command(OP_SLIDE, 0, 0, 30);
        send_command(OP_CAL, 0, 0, 45);
        send_command(OP_SAMPLE, 0, 0, 0);
        send_command(OP_SAMPLE, 0, 0, 0);
        send_command(OP_CAL, 0, 0, 55);
        send_command(OP_SAMPLE, 300, 0, 0);
        // scheduled on, same minute again, scheduled off
        send_command(OP_MINUTE, 0, 100, 0);
        send_command(OP_MINUTE, 0, 100, 0);
        send_command(OP_MINUTE, 0, 200, 0);
        send_command(OP_SAMPLE, 100, 0, 0);
        send_command(OP_WAKE, 0, 0, 0);
        send_command(OP_WAKE, 0, 0, 0);
        // idle timeout
        send_command(OP_MINUTE, 0, 1439, 0);
        send_command(OP_MINUTE, 0, 1024, 0);
        send_command(OP_MINUTE, 0, 203, 0);
        send_command(OP_OFF, 0, 0, 0);
        send_command(OP_WAKE, 0, 0, 0);
        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: load_settings(255, 0, 600, 1200, 0, 1, 60);
                1: load_settings(200, 40, $urandom_range(0, 1439), $urandom_range(0, 1439),
                                 5, 1, 1);
                2: load_settings(0, 255, 1439, 0, 1440, 1, 511);
                3: load_settings(128, 128, $urandom_range(0, 1439), $urandom_range(0, 1439),
                                 1, 0, $urandom_range(1, 511));
                default:
                begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                    if (phase != 6 && a < b)
                    begin
                        a = a + b;
                        b = a - b;
                        a = a - b;
                    end
                    case ($urandom_range(0, 2))
                        0: idle = 0;
                        1: idle = $urandom_range(1, 30);
                        default: idle = 1440;
                    endcase
                    sensor = (phase == 7) ? int'($urandom_range(0, 1)) : 1;
                    height = $urandom_range(1, 511);
                    load_settings(a, b, $urandom_range(0, 1439), $urandom_range(0, 1439),
                                  idle, sensor, height);
                end
            endcase
            clock_minute = $urandom_range(0, 1439);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 60 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send_random_item();
                if (i == PHASE_ITEMS / 2 && phase % 2 == 0)
                    drain_results();
            end
            no_idle = 1'b0;
            drain_results();
            repeat (SETTLE_TICKS) @(posedge clk);
        end

        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/abc_pkg.sv
rtl/core/abc_div.sv
rtl/core/abc_dp.sv
rtl/core/abc_ctrl.sv
rtl/core/ambient_backlight_controller.sv
dv/ambient_backlight_controller_test.sv
